### sv/sfpsp_pkg.sv
// Shared types, byte codes and the command length table for the serial frame parser.
// No dependencies; compiled first.
package sfpsp_pkg;

   localparam logic [7:0] HEADER_BYTE = 8'h55;
   localparam logic [7:0] CMD_D1      = 8'hD1;
   localparam logic [7:0] CMD_D2      = 8'hD2;
   localparam logic [7:0] CMD_D3      = 8'hD3;
   localparam logic [7:0] CMD_D4      = 8'hD4;
   localparam logic [7:0] CMD_D5      = 8'hD5;
   localparam logic [7:0] CMD_D6      = 8'hD6;
   localparam logic [7:0] CMD_D7      = 8'hD7;

   localparam int unsigned DATA_DEPTH  = 16;
   localparam logic [3:0]  NAME_COUNT  = 4'd8;

   typedef enum logic [3:0] {
      PH_HEADER  = 4'b0001,
      PH_COMMAND = 4'b0010,
      PH_DATA    = 4'b0100,
      PH_CHECK   = 4'b1000
   } phase_type;

   // One published frame: one record, or two fragments for a name frame.
   typedef struct packed {
      logic [31:0] seq0;
      logic [5:0]  idx0;
      logic [5:0]  idx1;
      logic [3:0]  count;
      logic [63:0] payload0;
      logic [63:0] payload1;
      logic        split;
   } rec_pair_type;

   // Data length of a command; zero marks an unknown command.
   function automatic logic [4:0] length_of(input logic [7:0] cmd);
      logic [4:0] len;
      case (cmd)
         CMD_D1:  len = 5'd3;
         CMD_D2:  len = 5'd3;
         CMD_D3:  len = 5'd1;
         CMD_D4:  len = 5'd2;
         CMD_D5:  len = 5'd3;
         CMD_D6:  len = 5'd6;
         CMD_D7:  len = 5'd16;
         default: len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

### sv/sfpsp_parser.sv
// Byte-level frame parser: header, command, data, checksum; builds the record pair.
// Uses sfpsp_pkg for codes, the phase type and the record pair struct.
module sfpsp_parser #(
   parameter int RING_DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_fire,
   input  logic [7:0]            rx_byte,
   output logic                  pub_valid,
   output sfpsp_pkg::rec_pair_type pub
);

   localparam int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int EW = IW + 6;

   sfpsp_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [4:0]  len_ff, len_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [7:0]  sum_ff, sum_in;
   logic [31:0] seq_ff, seq_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [7:0]  data_ff [sfpsp_pkg::DATA_DEPTH];

   logic        data_wr;
   logic [4:0]  cmd_len;
   logic        is_name;
   logic [31:0] seq_a, seq_b;
   logic [IW-1:0] idx_a, idx_b;
   logic [EW-1:0] ext_a, ext_b;
   logic [63:0] short_payload, name_lo, name_hi;

   assign cmd_len = sfpsp_pkg::length_of(rx_byte);
   assign is_name = (cmd_ff == sfpsp_pkg::CMD_D7);

   // Ring index follows the sequence; restart it when the sequence wraps.
   assign seq_a = seq_ff + 32'd1;
   assign seq_b = seq_ff + 32'd2;
   assign idx_a = (seq_a == 32'd0) ? '0 :
                  (idx_ff == IW'(RING_DEPTH - 1)) ? '0 : idx_ff + IW'(1);
   assign idx_b = (seq_b == 32'd0) ? '0 :
                  (idx_a == IW'(RING_DEPTH - 1)) ? '0 : idx_a + IW'(1);
   assign ext_a = EW'(idx_a);
   assign ext_b = EW'(idx_b);

   always_comb begin
      short_payload = '0;
      short_payload[7:0] = cmd_ff;
      for (int i = 0; i < 7; i++) begin
         short_payload[8*(i+1) +: 8] = (5'(i) < len_ff) ? data_ff[i] : 8'h00;
      end
      for (int i = 0; i < 8; i++) begin
         name_lo[8*i +: 8] = data_ff[i];
         name_hi[8*i +: 8] = data_ff[8+i];
      end
   end

   always_comb begin
      pub.seq0     = seq_a;
      pub.idx0     = ext_a[5:0];
      pub.idx1     = ext_b[5:0];
      pub.count    = is_name ? sfpsp_pkg::NAME_COUNT : 4'(len_ff) + 4'd1;
      pub.payload0 = is_name ? name_lo : short_payload;
      pub.payload1 = name_hi;
      pub.split    = is_name;
   end

   always_comb begin
      phase_in  = phase_ff;
      cmd_in    = cmd_ff;
      len_in    = len_ff;
      cnt_in    = cnt_ff;
      sum_in    = sum_ff;
      seq_in    = seq_ff;
      idx_in    = idx_ff;
      data_wr   = 1'b0;
      pub_valid = 1'b0;
      if (in_fire) begin
         case (phase_ff)
            sfpsp_pkg::PH_HEADER: begin
               if (rx_byte == sfpsp_pkg::HEADER_BYTE) begin
                  phase_in = sfpsp_pkg::PH_COMMAND;
                  sum_in   = rx_byte;
               end
            end
            sfpsp_pkg::PH_COMMAND: begin
               cmd_in = rx_byte;
               len_in = cmd_len;
               // drop unknown commands without rechecking the byte as a header
               if (cmd_len == 5'd0) begin
                  phase_in = sfpsp_pkg::PH_HEADER;
               end else begin
                  sum_in   = sum_ff + rx_byte;
                  cnt_in   = 5'd0;
                  phase_in = sfpsp_pkg::PH_DATA;
               end
            end
            sfpsp_pkg::PH_DATA: begin
               data_wr = 1'b1;
               cnt_in  = cnt_ff + 5'd1;
               sum_in  = sum_ff + rx_byte;
               if (cnt_in >= len_ff) begin
                  phase_in = sfpsp_pkg::PH_CHECK;
               end
            end
            sfpsp_pkg::PH_CHECK: begin
               phase_in = sfpsp_pkg::PH_HEADER;
               if (sum_ff == rx_byte) begin
                  pub_valid = 1'b1;
                  seq_in    = is_name ? seq_b : seq_a;
                  idx_in    = is_name ? idx_b : idx_a;
               end
            end
            default: begin
               phase_in = sfpsp_pkg::PH_HEADER;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sfpsp_pkg::PH_HEADER;
         cmd_ff   <= '0;
         len_ff   <= '0;
         cnt_ff   <= '0;
         sum_ff   <= '0;
         seq_ff   <= '0;
         idx_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         cmd_ff   <= cmd_in;
         len_ff   <= len_in;
         cnt_ff   <= cnt_in;
         sum_ff   <= sum_in;
         seq_ff   <= seq_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (data_wr) begin
         data_ff[cnt_ff[3:0]] <= rx_byte;
      end
   end

   // A frame spans at least four bytes, so publishes never come back to back.
   a_pub_spacing: assert property (@(posedge clock) disable iff (reset)
      pub_valid |=> !pub_valid)
      else $error("publish in consecutive cycles");

   a_data_len: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == sfpsp_pkg::PH_DATA) |-> (len_ff != 5'd0 && cnt_ff < len_ff))
      else $error("data phase with count past frame length");

endmodule

### sv/sfpsp_rec_queue.sv
// Two-entry queue of published frames; expands a name frame into two fragment records.
// Uses sfpsp_pkg::rec_pair_type.
module sfpsp_rec_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  sfpsp_pkg::rec_pair_type push_data,
   output logic                    full,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [31:0]             rsp_slot_sequence,
   output logic [5:0]              rsp_slot_index,
   output logic [3:0]              rsp_byte_count,
   output logic [63:0]             rsp_slot_payload,
   output logic                    rsp_split_flag,
   output logic                    rsp_split_part,
   output logic                    rsp_last
);

   sfpsp_pkg::rec_pair_type q_ff [2];
   sfpsp_pkg::rec_pair_type head;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       part_ff, part_in;
   logic       out_fire, pop;

   assign head      = q_ff[rd_ptr_ff];
   assign full      = (cnt_ff == 2'd2);
   assign rsp_valid = (cnt_ff != 2'd0);
   assign out_fire  = rsp_valid && !rsp_stall;
   // release the entry after its last record transfer
   assign pop       = out_fire && (!head.split || part_ff);

   assign rsp_slot_sequence = head.seq0 + 32'(part_ff);
   assign rsp_slot_index    = part_ff ? head.idx1 : head.idx0;
   assign rsp_byte_count    = head.count;
   assign rsp_slot_payload  = part_ff ? head.payload1 : head.payload0;
   assign rsp_split_flag    = head.split;
   assign rsp_split_part    = part_ff;
   assign rsp_last          = !head.split || part_ff;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
      part_in   = part_ff;
      if (out_fire) begin
         part_in = head.split && !part_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= '0;
         part_ff   <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
         part_ff   <= part_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (cnt_ff != 2'd2 || pop))
      else $error("push into full record queue");

   a_part_on_split: assert property (@(posedge clock) disable iff (reset)
      part_ff |-> (cnt_ff != 2'd0 && head.split))
      else $error("second fragment pending without a split entry");

endmodule

### sv/serial_frame_parser_slot_publisher_core.sv
// Top level of the serial frame parser and slot publisher.
// Instantiates sfpsp_parser and sfpsp_rec_queue; uses sfpsp_pkg.
//
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_stall  | req_rx_byte
//  rsp     | out       | rsp_valid / rsp_stall  | slot record fields
//
// One byte is taken per cycle while req_stall is low; the parser state updates in that cycle.
// A good frame enters the record queue at the checksum byte's edge and its
// first record is offered once it reaches the queue head; a name frame is offered as two fragment records.
// req_stall rises only while both queue entries hold frames.
// Reset (synchronous) returns the parser to header search and sequence zero.
module serial_frame_parser_slot_publisher_core #(
   parameter int RING_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_slot_sequence,
   output logic [5:0]  rsp_slot_index,
   output logic [3:0]  rsp_byte_count,
   output logic [63:0] rsp_slot_payload,
   output logic        rsp_split_flag,
   output logic        rsp_split_part,
   output logic        rsp_last
);

   logic                    in_fire;
   logic                    pub_valid;
   logic                    q_full;
   sfpsp_pkg::rec_pair_type pub;

   assign req_stall = q_full;
   assign in_fire   = req_valid && !q_full;

   sfpsp_parser #(
      .RING_DEPTH (RING_DEPTH)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .in_fire   (in_fire),
      .rx_byte   (req_rx_byte),
      .pub_valid (pub_valid),
      .pub       (pub)
   );

   sfpsp_rec_queue u_queue (
      .clock             (clock),
      .reset             (reset),
      .push              (pub_valid),
      .push_data         (pub),
      .full              (q_full),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_slot_sequence (rsp_slot_sequence),
      .rsp_slot_index    (rsp_slot_index),
      .rsp_byte_count    (rsp_byte_count),
      .rsp_slot_payload  (rsp_slot_payload),
      .rsp_split_flag    (rsp_split_flag),
      .rsp_split_part    (rsp_split_part),
      .rsp_last          (rsp_last)
   );

endmodule
